// ----- sv/ldat_pkg.sv -----
// ----------------------------------------------------------------------------
// ldat_pkg
// Shared codes and saturating arithmetic for the deadlock avoidance table.
// ----------------------------------------------------------------------------
package ldat_pkg;

  localparam logic [2:0] ACT_INIT     = 3'd0;
  localparam logic [2:0] ACT_REQUEST  = 3'd1;
  localparam logic [2:0] ACT_ACQUIRED = 3'd2;
  localparam logic [2:0] ACT_RELEASE  = 3'd3;
  localparam logic [2:0] ACT_ACTIVITY = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_RES = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  localparam logic CFG_DETECT_ENABLE = 1'b0;
  localparam logic CFG_RES_IN_USE    = 1'b1;

  typedef logic signed [15:0] cnt_t;

  function automatic cnt_t sat_add(input cnt_t a, input cnt_t b);
    logic signed [16:0] s;
    s = {a[15], a} + {b[15], b};
    if (s > 17'sd32767) return 16'sh7fff;
    else if (s < -17'sd32768) return 16'sh8000;
    else return s[15:0];
  endfunction

endpackage

// ----- sv/lock_deadlock_avoidance_table.sv -----
// ----------------------------------------------------------------------------
// lock_deadlock_avoidance_table
// Lock and semaphore bookkeeping with a Banker's-style safety check.
// ----------------------------------------------------------------------------
// Input channel in_*: one beat per operation (action, thread, resource, init
// count, thread activity). Output channel out_*: one status beat per input.
// Config port cfg_*: detect enable (index 0), resources in use (index 1);
// the user must write it only while idle; the block does not enforce this.
// Held counts and request flags live in one row-per-thread memory with a
// registered read; free counts, work counts and flags are registers.
// Init count and thread activity go straight to the status; with detect
// enabled, acquired and release read, update and write back the thread's
// row, and a request runs the safety pass, one row per cycle: one sweep to
// mark finished threads, then repeated sweeps until no thread finishes.
// One operation is in flight at a time.
// The output register holds a status while out_ready is low; the block
// then accepts the next beat but holds its status until the slot frees.
// Reset clears free counts, live flags, config and the row valid bits, so
// unwritten rows read as zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
module lock_deadlock_avoidance_table #(
  parameter int THREADS   = 16,
  parameter int RESOURCES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [3:0]  in_thread_id,
  input  logic [3:0]  in_resource_id,
  input  logic [14:0] in_init_count,
  input  logic        in_thread_active,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status
);

  localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int RW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
  localparam int CW = $clog2(THREADS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_INIT = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_FIX  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]             state_r;
  logic                   det_en_r;
  logic [4:0]             riu_r;
  ldat_pkg::cnt_t         free_r [RESOURCES];
  ldat_pkg::cnt_t         work_r [RESOURCES];
  logic [THREADS-1:0]     live_r;
  logic [THREADS-1:0]     fin_r;
  logic [THREADS-1:0]     row_vld_r;
  logic [RESOURCES-1:0][15:0] mem_held [THREADS];
  logic [RESOURCES-1:0]       mem_req  [THREADS];
  logic [RESOURCES-1:0][15:0] rd_held_r;
  logic [RESOURCES-1:0]       rd_req_r;
  logic                   rd_vld_r;
  logic [RESOURCES-1:0][15:0] row_held_r;
  logic [RESOURCES-1:0]       row_req_r;
  logic [2:0]             act_r;
  logic [TW-1:0]          t_r;
  logic [RW-1:0]          r_r;
  logic [1:0]             st_r;
  logic [CW-1:0]          cnt_r;
  logic                   d_vld_r;
  logic [TW-1:0]          d_idx_r;
  logic                   prog_r;
  logic                   out_valid_r;
  logic [1:0]             out_status_r;

  logic                   rd_en;
  logic [TW-1:0]          rd_addr;
  logic                   wr_en;
  logic [TW-1:0]          wr_addr;
  logic [RESOURCES-1:0][15:0] wr_held;
  logic [RESOURCES-1:0]       wr_req;
  logic [RESOURCES-1:0][15:0] dh;
  logic [RESOURCES-1:0]       dq;
  logic                   issue;
  logic                   holds;
  logic                   ok;
  logic                   take;
  logic                   t_ok;
  logic                   r_ok;
  logic                   r_in_tab;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign take       = in_valid && in_ready;
  assign t_ok       = 32'(in_thread_id) < THREADS;
  assign r_in_tab   = 32'(in_resource_id) < RESOURCES;
  assign r_ok       = r_in_tab && ({1'b0, in_resource_id} < riu_r);
  assign issue      = (32'(cnt_r) < THREADS);

  always_comb begin
    dh = rd_vld_r ? rd_held_r : '0;
    dq = rd_vld_r ? rd_req_r : '0;
    holds = 1'b0;
    ok = 1'b1;
    for (int j = 0; j < RESOURCES; j++) begin
      if ($signed(dh[j]) > 16'sd0) holds = 1'b1;
      if (dq[j] && (work_r[j] < 16'sd1)) ok = 1'b0;
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = t_r;
    wr_en   = 1'b0;
    wr_addr = t_r;
    wr_held = dh;
    wr_req  = dq;
    unique case (state_r)
      S_RD: rd_en = 1'b1;
      S_INIT, S_SCAN: begin
        rd_en   = issue;
        rd_addr = cnt_r[TW-1:0];
      end
      S_MOD: begin
        wr_en = 1'b1;
        if (act_r == ldat_pkg::ACT_REQUEST) begin
          wr_req[r_r] = 1'b1;
        end else if (act_r == ldat_pkg::ACT_ACQUIRED) begin
          wr_held[r_r] = ldat_pkg::sat_add(dh[r_r], 16'sd1);
          wr_req[r_r]  = 1'b0;
        end else begin
          wr_held[r_r] = ldat_pkg::sat_add(dh[r_r], -16'sd1);
        end
      end
      S_FIX: begin
        wr_en   = 1'b1;
        wr_held = row_held_r;
        wr_req  = row_req_r;
        wr_req[r_r] = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_held_r <= mem_held[rd_addr];
      rd_req_r  <= mem_req[rd_addr];
      rd_vld_r  <= row_vld_r[rd_addr];
    end
    if (wr_en) begin
      mem_held[wr_addr] <= wr_held;
      mem_req[wr_addr]  <= wr_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      det_en_r    <= 1'b0;
      riu_r       <= '0;
      live_r      <= '0;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
      d_vld_r     <= 1'b0;
      for (int j = 0; j < RESOURCES; j++) free_r[j] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          ldat_pkg::CFG_DETECT_ENABLE: det_en_r <= cfg_wdata[0];
          ldat_pkg::CFG_RES_IN_USE:    riu_r    <= cfg_wdata;
          default: ;
        endcase
      end
      if (wr_en) row_vld_r[wr_addr] <= 1'b1;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      d_vld_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (take) begin
            act_r   <= in_action;
            t_r     <= TW'(in_thread_id);
            r_r     <= RW'(in_resource_id);
            st_r    <= ldat_pkg::ST_OK;
            state_r <= S_OUT;
            if (in_action == ldat_pkg::ACT_INIT) begin
              if (r_in_tab) free_r[RW'(in_resource_id)] <= {1'b0, in_init_count};
              else st_r <= ldat_pkg::ST_BAD_RES;
            end else if (in_action == ldat_pkg::ACT_REQUEST ||
                         in_action == ldat_pkg::ACT_ACQUIRED ||
                         in_action == ldat_pkg::ACT_RELEASE) begin
              if (!r_ok) st_r <= ldat_pkg::ST_BAD_RES;
              else if (t_ok && det_en_r) state_r <= S_RD;
            end else if (in_action == ldat_pkg::ACT_ACTIVITY) begin
              if (t_ok) live_r[TW'(in_thread_id)] <= in_thread_active;
            end
          end
        end
        S_RD: state_r <= S_MOD;
        S_MOD: begin
          if (act_r == ldat_pkg::ACT_REQUEST) begin
            row_held_r <= wr_held;
            row_req_r  <= wr_req;
            for (int j = 0; j < RESOURCES; j++) work_r[j] <= free_r[j];
            cnt_r   <= '0;
            state_r <= S_INIT;
          end else begin
            if (act_r == ldat_pkg::ACT_ACQUIRED)
              free_r[r_r] <= ldat_pkg::sat_add(free_r[r_r], -16'sd1);
            else
              free_r[r_r] <= ldat_pkg::sat_add(free_r[r_r], 16'sd1);
            state_r <= S_OUT;
          end
        end
        S_INIT, S_SCAN: begin
          if (issue) cnt_r <= cnt_r + 1'b1;
          d_vld_r <= issue;
          d_idx_r <= cnt_r[TW-1:0];
          if (d_vld_r) begin
            if (state_r == S_INIT) begin
              fin_r[d_idx_r] <= !live_r[d_idx_r] || !holds;
              if (32'(d_idx_r) == THREADS - 1) begin
                cnt_r   <= '0;
                d_vld_r <= 1'b0;
                prog_r  <= 1'b0;
                state_r <= S_SCAN;
              end
            end else begin
              if (!fin_r[d_idx_r] && ok) begin
                for (int j = 0; j < RESOURCES; j++)
                  work_r[j] <= ldat_pkg::sat_add(work_r[j], dh[j]);
                fin_r[d_idx_r] <= 1'b1;
              end
              if (32'(d_idx_r) == THREADS - 1) begin
                cnt_r   <= '0;
                d_vld_r <= 1'b0;
                prog_r  <= 1'b0;
                if (!(prog_r || (!fin_r[d_idx_r] && ok))) begin
                  if (!(&fin_r)) begin
                    st_r    <= ldat_pkg::ST_REFUSED;
                    state_r <= S_FIX;
                  end else begin
                    state_r <= S_OUT;
                  end
                end
              end else if (!fin_r[d_idx_r] && ok) begin
                prog_r <= 1'b1;
              end
            end
          end
        end
        S_FIX: state_r <= S_OUT;
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= st_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
